@@ sv/spbf_pkg.sv @@
// ============================================================================
// spbf_pkg: shared constants of the sun-pointing body frame core
// Default configuration, mantissa width of block-reduced vectors, and the
// packing widths of the result item.
// ============================================================================
package spbf_pkg;

    localparam int COORD_BITS_DEF    = 40;  // input coordinate width
    localparam int OUT_FRAC_BITS_DEF = 30;  // fraction bits of each axis entry
    localparam int MANT_BITS         = 30;  // magnitude bits after reduction
    localparam int AXIS_W            = 32;  // width of one axis entry
    localparam int AXIS_CNT          = 9;   // entries in the rotation matrix
    localparam int OUT_TDATA_W       = AXIS_W * AXIS_CNT;

endpackage

@@ sv/sun_pointing_body_frame_core.sv @@
// ============================================================================
// sun_pointing_body_frame_core: nominal yaw-steering body frame
// Builds the body axes of a navigation satellite from its position and the
// sun position: Z toward Earth center, Y along Z x sun direction, X = Y x Z.
// Results are nine unit-vector entries in signed fixed point.
// ============================================================================
//
// Channel   Dir  Handshake             Payload
// -------   ---  --------------------  ------------------------------------
// s_        in   s_tvalid / s_tready   s_tdata: sat_x,y,z, sun_x,y,z
// m_        out  m_tvalid / m_tready   m_tdata: axis_x_0..axis_z_2
//                                      m_tuser: degenerate
//
// One item enters per clock while the output is not stalled. The depth is
// set by the 31-step square-root pipeline and the OUT_FRAC_BITS + 2 step
// restoring dividers, one bit per stage.
// aresetn (synchronous, active low) clears only the stage valid bits.
// All stages advance together while the output register is empty or taken;
// when m_tready is low with a result shown, every stage holds and
// s_tready drops, so nothing is lost or repeated.
//
module sun_pointing_body_frame_core #(
    parameter int COORD_BITS    = spbf_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = spbf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sat_x, sat_y, sat_z, sun_x, sun_y, sun_z (COORD_BITS each), zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // axis_x_0, axis_x_1, axis_x_2, axis_y_0, .., axis_z_2 (32 bits each)
    output logic [spbf_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // degenerate
    output logic                                   m_tuser
);

    localparam int CB  = COORD_BITS;
    localparam int MB  = spbf_pkg::MANT_BITS;
    localparam int VW  = MB + 1;            // reduced signed component
    localparam int PW  = 2 * MB + 2;        // cross-product terms
    localparam int SHW = $clog2(PW + 1);    // reduction shift amount
    localparam int SSW = 2 * MB + 2;        // sum of squares
    localparam int SQ  = MB + 1;            // square-root steps
    localparam int NW  = MB + 1;            // norm
    localparam int RW  = MB + 2;            // divider remainder
    localparam int QW  = OUT_FRAC_BITS + 2; // divider quotient
    localparam int DV  = OUT_FRAC_BITS + 1; // divider steps
    localparam int OW  = spbf_pkg::AXIS_W;
    localparam int EW  = (QW + 1 > OW) ? QW + 1 : OW;
    localparam int NFRONT = 12;
    localparam int NST = NFRONT + (SQ + 1) + (DV + 1) + 1;

    // Shift that brings the largest magnitude down to MB significant bits.
    function automatic logic [SHW-1:0] red_shift(input logic [PW-1:0] v);
        logic [SHW-1:0] bl;
        bl = '0;
        for (int i = 0; i < PW; i++) begin
            if (v[i]) begin
                bl = SHW'(i + 1);
            end
        end
        return (bl > SHW'(MB)) ? bl - SHW'(MB) : '0;
    endfunction

    function automatic logic signed [VW-1:0] signed_of(input logic [MB-1:0] m,
                                                       input logic s);
        logic signed [VW-1:0] p;
        p = $signed({1'b0, m});
        return s ? -p : p;
    endfunction

    logic ce;
    logic [NST-1:0] vld_reg;

    // advance every stage while the output register is free or being taken
    assign ce       = !vld_reg[NST-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------- front
    logic [CB-1:0]         sat_reg [0:2];
    logic [CB-1:0]         sun_reg [0:2];
    logic [CB-1:0]         smag_reg [0:2];
    logic [CB-1:0]         pmag_reg [0:2];
    logic                  ssg_reg [0:2];
    logic                  psg_reg [0:2];
    logic [SHW-1:0]        s_sh_reg, p_sh_reg;
    logic signed [VW-1:0]  sr_reg [0:2];
    logic signed [VW-1:0]  pr_reg [0:2];
    logic signed [PW-1:0]  cp_reg [0:5];
    logic signed [VW-1:0]  sr3_reg [0:2];
    logic signed [PW-1:0]  c_reg [0:2];
    logic signed [VW-1:0]  sr4_reg [0:2];
    logic [PW-1:0]         cmag_reg [0:2];
    logic                  csg_reg [0:2];
    logic [SHW-1:0]        c_sh_reg;
    logic signed [VW-1:0]  sr5_reg [0:2];
    logic signed [VW-1:0]  ym_reg [0:2];
    logic signed [VW-1:0]  sr6_reg [0:2];
    logic signed [PW-1:0]  dp_reg [0:5];
    logic signed [VW-1:0]  ym7_reg [0:2];
    logic signed [VW-1:0]  sr7_reg [0:2];
    logic signed [PW-1:0]  d_reg [0:2];
    logic signed [VW-1:0]  ym8_reg [0:2];
    logic signed [VW-1:0]  sr8_reg [0:2];
    logic [PW-1:0]         dmag_reg [0:2];
    logic                  dsg0_reg [0:2];
    logic [SHW-1:0]        d_sh_reg;
    logic signed [VW-1:0]  ym9_reg [0:2];
    logic signed [VW-1:0]  sr9_reg [0:2];
    logic signed [VW-1:0]  xm_reg [0:2];
    logic signed [VW-1:0]  ym10_reg [0:2];
    logic signed [VW-1:0]  sr10_reg [0:2];
    logic [MB-1:0]         am_reg [0:2][0:2];
    logic                  as_reg [0:2][0:2];
    logic [2*MB-1:0]       sq_reg [0:2][0:2];

    logic [CB-1:0]         smag_c [0:2];
    logic [CB-1:0]         pmag_c [0:2];
    logic [CB-1:0]         sor_c, por_c;
    logic [PW-1:0]         cmag_c [0:2];
    logic [PW-1:0]         dmag_c [0:2];
    logic [PW-1:0]         cor_c, dor_c;
    logic [PW-1:0]         csh_c [0:2];
    logic [PW-1:0]         dsh_c [0:2];
    logic [PW-1:0]         ssh_c [0:2];
    logic [PW-1:0]         psh_c [0:2];
    logic signed [VW-1:0]  vec_c [0:2][0:2];
    logic [MB-1:0]         am_c [0:2][0:2];
    logic                  as_c [0:2][0:2];

    always_comb begin
        sor_c = '0;
        por_c = '0;
        cor_c = '0;
        dor_c = '0;
        for (int i = 0; i < 3; i++) begin
            smag_c[i] = sat_reg[i][CB-1] ? (~sat_reg[i] + 1'b1) : sat_reg[i];
            pmag_c[i] = sun_reg[i][CB-1] ? (~sun_reg[i] + 1'b1) : sun_reg[i];
            sor_c     = sor_c | smag_c[i];
            por_c     = por_c | pmag_c[i];
            cmag_c[i] = c_reg[i][PW-1] ? PW'(-c_reg[i]) : PW'(c_reg[i]);
            dmag_c[i] = d_reg[i][PW-1] ? PW'(-d_reg[i]) : PW'(d_reg[i]);
            cor_c     = cor_c | cmag_c[i];
            dor_c     = dor_c | dmag_c[i];
            ssh_c[i]  = PW'(smag_reg[i]) >> s_sh_reg;
            psh_c[i]  = PW'(pmag_reg[i]) >> p_sh_reg;
            csh_c[i]  = cmag_reg[i] >> c_sh_reg;
            dsh_c[i]  = dmag_reg[i] >> d_sh_reg;
            // vector 0 = X, 1 = Y, 2 = Z (Z is the negated satellite vector)
            vec_c[0][i] = xm_reg[i];
            vec_c[1][i] = ym10_reg[i];
            vec_c[2][i] = sr10_reg[i];
        end
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                am_c[v][i] = vec_c[v][i][VW-1] ? MB'(-vec_c[v][i]) : MB'(vec_c[v][i]);
                as_c[v][i] = vec_c[v][i][VW-1];
            end
        end
        for (int i = 0; i < 3; i++) begin
            as_c[2][i] = !sr10_reg[i][VW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                // capture and sign-magnitude split
                sat_reg[i]  <= s_tdata[i*CB +: CB];
                sun_reg[i]  <= s_tdata[(3+i)*CB +: CB];
                smag_reg[i] <= smag_c[i];
                pmag_reg[i] <= pmag_c[i];
                ssg_reg[i]  <= sat_reg[i][CB-1];
                psg_reg[i]  <= sun_reg[i][CB-1];
                // block reduction of satellite and sun
                sr_reg[i]   <= signed_of(ssh_c[i][MB-1:0], ssg_reg[i]);
                pr_reg[i]   <= signed_of(psh_c[i][MB-1:0], psg_reg[i]);
                sr3_reg[i]  <= sr_reg[i];
                c_reg[i]    <= cp_reg[2*i] - cp_reg[2*i+1];
                sr4_reg[i]  <= sr3_reg[i];
                cmag_reg[i] <= cmag_c[i];
                csg_reg[i]  <= c_reg[i][PW-1];
                sr5_reg[i]  <= sr4_reg[i];
                ym_reg[i]   <= signed_of(csh_c[i][MB-1:0], csg_reg[i]);
                sr6_reg[i]  <= sr5_reg[i];
                ym7_reg[i]  <= ym_reg[i];
                sr7_reg[i]  <= sr6_reg[i];
                d_reg[i]    <= dp_reg[2*i] - dp_reg[2*i+1];
                ym8_reg[i]  <= ym7_reg[i];
                sr8_reg[i]  <= sr7_reg[i];
                dmag_reg[i] <= dmag_c[i];
                dsg0_reg[i] <= d_reg[i][PW-1];
                ym9_reg[i]  <= ym8_reg[i];
                sr9_reg[i]  <= sr8_reg[i];
                xm_reg[i]   <= signed_of(dsh_c[i][MB-1:0], dsg0_reg[i]);
                ym10_reg[i] <= ym9_reg[i];
                sr10_reg[i] <= sr9_reg[i];
            end
            s_sh_reg <= red_shift(PW'(sor_c));
            p_sh_reg <= red_shift(PW'(por_c));
            c_sh_reg <= red_shift(cor_c);
            d_sh_reg <= red_shift(dor_c);
            // C = Pr x Sr
            cp_reg[0] <= pr_reg[1] * sr_reg[2];
            cp_reg[1] <= pr_reg[2] * sr_reg[1];
            cp_reg[2] <= pr_reg[2] * sr_reg[0];
            cp_reg[3] <= pr_reg[0] * sr_reg[2];
            cp_reg[4] <= pr_reg[0] * sr_reg[1];
            cp_reg[5] <= pr_reg[1] * sr_reg[0];
            // D = Ym x Zm = Sr x Ym, since Zm = -Sr
            dp_reg[0] <= sr6_reg[1] * ym_reg[2];
            dp_reg[1] <= sr6_reg[2] * ym_reg[1];
            dp_reg[2] <= sr6_reg[2] * ym_reg[0];
            dp_reg[3] <= sr6_reg[0] * ym_reg[2];
            dp_reg[4] <= sr6_reg[0] * ym_reg[1];
            dp_reg[5] <= sr6_reg[1] * ym_reg[0];
            for (int v = 0; v < 3; v++) begin
                for (int i = 0; i < 3; i++) begin
                    am_reg[v][i] <= am_c[v][i];
                    as_reg[v][i] <= as_c[v][i];
                    sq_reg[v][i] <= am_c[v][i] * am_c[v][i];
                end
            end
        end
    end

    // ---------------------------------------------------------- square root
    logic [SSW-1:0] sqx_reg [0:SQ][0:2];
    logic [SSW-1:0] sqr_reg [0:SQ][0:2];
    logic [MB-1:0]  sam_reg [0:SQ][0:2][0:2];
    logic           ssg_q_reg [0:SQ][0:2][0:2];
    logic           sdg_reg [0:SQ];
    logic [SSW-1:0] sqx_next [0:SQ][0:2];
    logic [SSW-1:0] sqr_next [0:SQ][0:2];
    logic [MB-1:0]  sam_next [0:SQ][0:2][0:2];
    logic           ssg_q_next [0:SQ][0:2][0:2];
    logic           sdg_next [0:SQ];

    always_comb begin
        logic [SSW-1:0] bitv;
        logic [SSW:0]   tv;
        sdg_next[0] = 1'b0;
        for (int v = 0; v < 3; v++) begin
            sqx_next[0][v] = SSW'(sq_reg[v][0]) + SSW'(sq_reg[v][1]) + SSW'(sq_reg[v][2]);
            sqr_next[0][v] = '0;
            if (sqx_next[0][v] == '0) begin
                sdg_next[0] = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                sam_next[0][v][i]   = am_reg[v][i];
                ssg_q_next[0][v][i] = as_reg[v][i];
            end
        end
        for (int j = 0; j < SQ; j++) begin
            bitv = SSW'(1) << (2 * (SQ - 1 - j));
            sdg_next[j+1] = sdg_reg[j];
            for (int v = 0; v < 3; v++) begin
                tv = {1'b0, sqr_reg[j][v]} + {1'b0, bitv};
                if ({1'b0, sqx_reg[j][v]} >= tv) begin
                    sqx_next[j+1][v] = sqx_reg[j][v] - tv[SSW-1:0];
                    sqr_next[j+1][v] = (sqr_reg[j][v] >> 1) + bitv;
                end else begin
                    sqx_next[j+1][v] = sqx_reg[j][v];
                    sqr_next[j+1][v] = sqr_reg[j][v] >> 1;
                end
                for (int i = 0; i < 3; i++) begin
                    sam_next[j+1][v][i]   = sam_reg[j][v][i];
                    ssg_q_next[j+1][v][i] = ssg_q_reg[j][v][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sqx_reg   <= sqx_next;
            sqr_reg   <= sqr_next;
            sam_reg   <= sam_next;
            ssg_q_reg <= ssg_q_next;
            sdg_reg   <= sdg_next;
        end
    end

    // --------------------------------------------------------------- divide
    logic [RW-1:0] dr_reg [0:DV][0:2][0:2];
    logic [QW-1:0] dq_reg [0:DV][0:2][0:2];
    logic [NW-1:0] dn_reg [0:DV][0:2];
    logic          dsg_reg [0:DV][0:2][0:2];
    logic          ddg_reg [0:DV];
    logic [RW-1:0] dr_next [0:DV][0:2][0:2];
    logic [QW-1:0] dq_next [0:DV][0:2][0:2];
    logic [NW-1:0] dn_next [0:DV][0:2];
    logic          dsg_next [0:DV][0:2][0:2];
    logic          ddg_next [0:DV];

    always_comb begin
        logic [RW-1:0] av, nv, r2;
        logic          ge;
        ddg_next[0] = sdg_reg[SQ];
        for (int v = 0; v < 3; v++) begin
            dn_next[0][v] = sqr_reg[SQ][v][NW-1:0];
            nv = RW'(sqr_reg[SQ][v][NW-1:0]);
            for (int i = 0; i < 3; i++) begin
                // integer part: component never exceeds the norm
                av = RW'(sam_reg[SQ][v][i]);
                ge = (av >= nv);
                dr_next[0][v][i]  = ge ? av - nv : av;
                dq_next[0][v][i]  = QW'(ge);
                dsg_next[0][v][i] = ssg_q_reg[SQ][v][i];
            end
        end
        for (int j = 0; j < DV; j++) begin
            ddg_next[j+1] = ddg_reg[j];
            for (int v = 0; v < 3; v++) begin
                dn_next[j+1][v] = dn_reg[j][v];
                nv = RW'(dn_reg[j][v]);
                for (int i = 0; i < 3; i++) begin
                    r2 = {dr_reg[j][v][i][RW-2:0], 1'b0};
                    ge = (r2 >= nv);
                    dr_next[j+1][v][i]  = ge ? r2 - nv : r2;
                    dq_next[j+1][v][i]  = {dq_reg[j][v][i][QW-2:0], ge};
                    dsg_next[j+1][v][i] = dsg_reg[j][v][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dr_reg  <= dr_next;
            dq_reg  <= dq_next;
            dn_reg  <= dn_next;
            dsg_reg <= dsg_next;
            ddg_reg <= ddg_next;
        end
    end

    // --------------------------------------------------------------- output
    logic [OW-1:0]        axis_reg [0:spbf_pkg::AXIS_CNT-1];
    logic                 degen_reg;
    logic [OW-1:0]        axis_next [0:spbf_pkg::AXIS_CNT-1];
    logic [QW:0]          rnd_c;
    logic signed [EW-1:0] sv_c;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                // round half up on the magnitude, then restore the sign
                rnd_c = ({1'b0, dq_reg[DV][v][i]} + 1'b1) >> 1;
                sv_c  = $signed(EW'(rnd_c[QW-1:0]));
                if (dsg_reg[DV][v][i]) begin
                    sv_c = -sv_c;
                end
                axis_next[3*v+i] = ddg_reg[DV] ? '0 : sv_c[OW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            axis_reg  <= axis_next;
            degen_reg <= ddg_reg[DV];
        end
    end

    always_comb begin
        for (int k = 0; k < spbf_pkg::AXIS_CNT; k++) begin
            m_tdata[k*OW +: OW] = axis_reg[k];
        end
    end
    assign m_tuser = degen_reg;

endmodule

@@ sim/tb_top.sv @@
// ============================================================================
// tb_top: self-checking bench for the sun-pointing body frame core
// Streams satellite and sun positions into the core, predicts each body
// frame with a bit-exact integer model and compares every result item field
// by field, under several sender and receiver idling patterns.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB          = spbf_pkg::COORD_BITS_DEF;
    localparam int FB          = spbf_pkg::OUT_FRAC_BITS_DEF;
    localparam int MANT_BITS   = spbf_pkg::MANT_BITS;
    localparam int AXIS_W      = spbf_pkg::AXIS_W;
    localparam int AXIS_CNT    = spbf_pkg::AXIS_CNT;
    localparam int OUT_TDATA_W = spbf_pkg::OUT_TDATA_W;
    localparam int IN_W        = ((6*CB+7)/8)*8;
    localparam int LATENCY     = FB + 47;
    localparam int N_RAND      = 2000;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        logic [OUT_TDATA_W-1:0] axes;
        logic                   degenerate;
    } frame_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;   // sat_x, sat_y, sat_z, sun_x, sun_y, sun_z
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // axis_x_0 .. axis_z_2
    logic                   m_tuser;   // degenerate

    sun_pointing_body_frame_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    frame_t pending_frames[$];
    int     n_errors;
    int     n_checked;
    int     n_degenerate;
    int     send_idle_pct;
    int     recv_stall_pct;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Shift all magnitudes right so the largest fits the mantissa width.
    function automatic void block_reduce(input longint v[3], output longint r[3]);
        longint unsigned m;
        longint unsigned a;
        int nbits;
        int sh;
        m = 0;
        nbits = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
            if (abs64(v[i]) > m) m = abs64(v[i]);
        while (nbits < 64 && (m >> nbits) != 0) nbits++;
        if (nbits > MANT_BITS) sh = nbits - MANT_BITS;
        for (int i = 0; i < 3; i++) begin
            a = abs64(v[i]) >> sh;
            r[i] = v[i] < 0 ? -longint'(a) : longint'(a);
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint r[3]);
        r[0] = a[1]*b[2] - a[2]*b[1];
        r[1] = a[2]*b[0] - a[0]*b[2];
        r[2] = a[0]*b[1] - a[1]*b[0];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Normalize a reduced vector to FB fraction bits, rounding half up.
    function automatic bit normalize(input longint v[3], output longint u[3]);
        longint unsigned ss;
        longint unsigned n;
        longint unsigned q;
        longint unsigned rem;
        ss = 0;
        for (int i = 0; i < 3; i++) ss += abs64(v[i]) * abs64(v[i]);
        if (ss == 0) return 1'b0;
        n = floor_sqrt(ss);
        for (int i = 0; i < 3; i++) begin
            q = abs64(v[i]) / n;
            rem = abs64(v[i]) % n;
            for (int k = 0; k < FB + 1; k++) begin
                rem <<= 1;
                q <<= 1;
                if (rem >= n) begin
                    rem -= n;
                    q |= 1;
                end
            end
            q = (q + 1) >> 1;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic frame_t body_frame(coord_t sat[3], coord_t sun[3]);
        longint s[3], p[3], ns[3], sr[3], pr[3], zm[3], c[3], ym[3], d[3], xm[3];
        longint ux[3], uy[3], uz[3];
        bit ok;
        frame_t f;
        for (int i = 0; i < 3; i++) begin
            s[i] = longint'(sat[i]);
            p[i] = longint'(sun[i]);
            ns[i] = -s[i];
        end
        block_reduce(ns, zm);
        block_reduce(s, sr);
        block_reduce(p, pr);
        cross3(pr, sr, c);
        block_reduce(c, ym);
        cross3(ym, zm, d);
        block_reduce(d, xm);
        ok = normalize(zm, uz);
        if (ok) ok = normalize(ym, uy);
        if (ok) ok = normalize(xm, ux);
        f.axes = '0;
        f.degenerate = !ok;
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                f.axes[i*AXIS_W +: AXIS_W]     = ux[i][AXIS_W-1:0];
                f.axes[(3+i)*AXIS_W +: AXIS_W] = uy[i][AXIS_W-1:0];
                f.axes[(6+i)*AXIS_W +: AXIS_W] = uz[i][AXIS_W-1:0];
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold the item until accepted, idle at random between items
    // ------------------------------------------------------------------
    task automatic send_position(coord_t sat[3], coord_t sun[3],
                                 bit check_fixed, frame_t fixed_frame);
        logic [IN_W-1:0] packed_pos;
        frame_t predicted;
        packed_pos = '0;
        for (int i = 0; i < 3; i++) begin
            packed_pos[i*CB +: CB]     = sat[i];
            packed_pos[(3+i)*CB +: CB] = sun[i];
        end
        predicted = body_frame(sat, sun);
        if (check_fixed && (predicted.axes !== fixed_frame.axes ||
                            predicted.degenerate !== fixed_frame.degenerate))
            report_mismatch("predictor disagrees with typed-in frame");
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packed_pos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // queue after acceptance so output can never race ahead of it
        pending_frames.push_back(predicted);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, compare each accepted item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        frame_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = pending_frames.pop_front();
                    n_checked++;
                    if (want.degenerate) n_degenerate++;
                    for (int i = 0; i < AXIS_CNT; i++)
                        if (m_tdata[i*AXIS_W +: AXIS_W] !== want.axes[i*AXIS_W +: AXIS_W])
                            report_mismatch($sformatf("axis %0d got %h want %h", i,
                                m_tdata[i*AXIS_W +: AXIS_W], want.axes[i*AXIS_W +: AXIS_W]));
                    if (m_tuser !== want.degenerate)
                        report_mismatch($sformatf("degenerate got %b want %b",
                                                  m_tuser, want.degenerate));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            m_tready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam longint ONE_Q = longint'(1) << FB;

    typedef struct {
        coord_t sat[3];
        coord_t sun[3];
        bit     fixed;
        frame_t frame;
    } vector_row_t;

    vector_row_t directed_rows[$];

    function automatic frame_t axes_frame(longint ax[3], longint ay[3], longint az[3]);
        frame_t f;
        f.degenerate = 1'b0;
        for (int i = 0; i < 3; i++) begin
            f.axes[i*AXIS_W +: AXIS_W]     = ax[i][AXIS_W-1:0];
            f.axes[(3+i)*AXIS_W +: AXIS_W] = ay[i][AXIS_W-1:0];
            f.axes[(6+i)*AXIS_W +: AXIS_W] = az[i][AXIS_W-1:0];
        end
        return f;
    endfunction

    function automatic void add_row(coord_t a0, coord_t a1, coord_t a2,
                                    coord_t b0, coord_t b1, coord_t b2,
                                    bit fixed, frame_t f);
        vector_row_t r;
        r.sat = '{a0, a1, a2};
        r.sun = '{b0, b1, b2};
        r.fixed = fixed;
        r.frame = f;
        directed_rows.push_back(r);
    endfunction

    function automatic coord_t rand_coord(int mag_bits);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (mag_bits < CB) raw = raw & ((64'd1 << mag_bits) - 1);
        if (mag_bits < CB && $urandom_range(1)) return -coord_t'(raw[CB-1:0]);
        return raw[CB-1:0];
    endfunction

    function automatic coord_t near_coord(coord_t c);
        return c + coord_t'(int'($urandom_range(2000)) - 1000);
    endfunction

    initial begin
        frame_t degen;
        frame_t none;
        coord_t sat[3];
        coord_t sun[3];
        int phase_pct[4][2];
        int kind;
        int mb;
        degen.axes = '0;
        degen.degenerate = 1'b1;
        none = degen;
        phase_pct = '{'{0, 0}, '{87, 0}, '{0, 87}, '{26, 26}};
        n_errors = 0;
        n_checked = 0;
        n_degenerate = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero satellite, zero sun, sun on the line of sight
        add_row(0, 0, 0, 1000, 2000, 3000, 1, degen);
        add_row(7, 0, 0, 0, 0, 0, 1, degen);
        add_row(0, 0, 0, 0, 0, 0, 1, degen);
        add_row(100, 200, 300, 200, 400, 600, 1, degen);
        add_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, degen);
        add_row(CMIN, 0, 0, CMAX, 0, 0, 1, degen);
        // sat on +X, sun on +Y: Z=-X, Y=-Z_earth, X=+Y
        add_row(1000, 0, 0, 0, 1000, 0, 1,
                axes_frame('{0, ONE_Q, 0}, '{0, 0, -ONE_Q}, '{-ONE_Q, 0, 0}));
        add_row(CMAX, 0, 0, 0, CMAX, 0, 1,
                axes_frame('{0, ONE_Q, 0}, '{0, 0, -ONE_Q}, '{-ONE_Q, 0, 0}));
        add_row(CMIN, 0, 0, 0, CMIN, 0, 0, none);
        add_row(0, 0, CMIN, CMAX, 0, 0, 0, none);
        add_row(0, CMAX, 0, 0, 0, CMIN, 0, none);
        add_row(CMAX, CMIN, CMAX, CMIN, CMAX, 1, 0, none);
        add_row(1, 0, 0, 0, 1, 0, 0, none);
        add_row(-1, -1, -1, 1, -1, 1, 0, none);
        add_row(CMIN, CMIN, CMIN, 1, 2, 3, 0, none);
        add_row(26560000, 0, 0, 0, 149597870, 10, 0, none);
        add_row(-13000000, 20000000, 9000000, coord_t'(64'sd149000000000),
                coord_t'(-64'sd12000000000), coord_t'(64'sd5000000000), 0, none);
        foreach (directed_rows[i])
            send_position(directed_rows[i].sat, directed_rows[i].sun,
                          directed_rows[i].fixed, directed_rows[i].frame);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < N_RAND / 4; n++) begin
                kind = $urandom_range(99);
                mb = $urandom_range(CB, 1);
                for (int i = 0; i < 3; i++) begin
                    sat[i] = rand_coord(mb);
                    sun[i] = rand_coord($urandom_range(CB, 1));
                end
                if (kind < 4) begin
                    // sun on the line of sight, scaled copy of the satellite
                    for (int i = 0; i < 3; i++) sun[i] = sat[i] * coord_t'(2);
                end else if (kind < 8) begin
                    sun = '{0, 0, 0};
                end else if (kind < 12) begin
                    sat = '{0, 0, 0};
                end else if (kind < 20) begin
                    // nearly aligned: tests reduction of a tiny cross product
                    for (int i = 0; i < 3; i++) sun[i] = near_coord(sat[i]);
                end else if (kind < 26) begin
                    for (int i = 0; i < 3; i++) begin
                        sat[i] = $urandom_range(1) ? CMAX : CMIN;
                        if ($urandom_range(2) == 0) sat[i] = 0;
                    end
                end
                send_position(sat, sun, 0, none);
            end
            // drop valid and let the pipe drain between idling patterns
            s_tvalid <= 1'b0;
            while (pending_frames.size() != 0) @(posedge aclk);
        end

        repeat (2 * LATENCY) @(posedge aclk);
        $display("Checked %0d frames (%0d degenerate) over four idling patterns.",
                 n_checked, n_degenerate);
        if (n_errors == 0 && pending_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d frames never arrived", n_errors,
                     pending_frames.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Worst case is about 2000 items with random idling before each, each
    // waiting out receiver stalls, plus drain; 400 us leaves wide margin.
    initial begin
        #400us;
        $display("timeout with %0d frames outstanding", pending_frames.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
sv/spbf_pkg.sv
sv/sun_pointing_body_frame_core.sv
sim/tb_top.sv
